[hw/rtl/nir_pkg.sv]
// ----------------------------------------------------------------------------
// NEC IR pulse decoder package
// Shared types, timing windows and helper functions for the decoder blocks.
// ----------------------------------------------------------------------------
package nir_pkg;

  localparam logic [15:0] LEADER_LOW_MIN  = 16'd8500;
  localparam logic [15:0] LEADER_LOW_MAX  = 16'd9500;
  localparam logic [15:0] LEADER_HIGH_MIN = 16'd4000;
  localparam logic [15:0] LEADER_HIGH_MAX = 16'd5500;
  localparam logic [15:0] REPEAT_HIGH_MIN = 16'd2000;
  localparam logic [15:0] REPEAT_HIGH_MAX = 16'd3000;
  localparam logic [15:0] MARK_MIN        = 16'd450;
  localparam logic [15:0] MARK_MAX        = 16'd650;
  localparam logic [15:0] ONE_HIGH_MIN    = 16'd1450;
  localparam logic [15:0] ONE_HIGH_MAX    = 16'd1750;
  localparam logic [7:0]  REPEAT_CAP      = 8'd250;
  localparam logic [7:0]  BYTE_ALL        = 8'hff;
  localparam logic [5:0]  FRAME_BITS      = 6'd32;
  localparam logic [15:0] HOLD_TIMEOUT_RESET = 16'd100;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_EDGE     = 2'd0,
    OP_OVERFLOW = 2'd1,
    OP_TICK     = 2'd2,
    OP_POLL     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KEY_RELEASED = 2'd0,
    KEY_HELD     = 2'd1,
    KEY_PENDING  = 2'd2
  } key_t;

  // Which timing windows a pulse width falls into.
  typedef struct packed {
    logic leader_low;
    logic leader_high;
    logic repeat_high;
    logic mark;
    logic one_high;
  } pulse_class_t;

  typedef struct packed {
    op_t          op;
    pulse_class_t cls;
  } queue_entry_t;

  function automatic logic in_window(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Low byte is the value, high byte must be its complement.
  function automatic logic [7:0] checked_byte(logic [15:0] pair);
    return ((pair[7:0] ^ pair[15:8]) == BYTE_ALL) ? pair[7:0] : 8'd0;
  endfunction

endpackage

[hw/rtl/nir_front.sv]
// ----------------------------------------------------------------------------
// NEC IR decoder front end
// Accepts items, decodes the operation and classifies the pulse width.
// ----------------------------------------------------------------------------
module nir_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [15:0]           pulse_time,
  input  logic                  full,
  output logic                  push,
  output nir_pkg::queue_entry_t entry
);
  import nir_pkg::*;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    entry.op              = op_t'(op);
    entry.cls.leader_low  = in_window(pulse_time, LEADER_LOW_MIN, LEADER_LOW_MAX);
    entry.cls.leader_high = in_window(pulse_time, LEADER_HIGH_MIN, LEADER_HIGH_MAX);
    entry.cls.repeat_high = in_window(pulse_time, REPEAT_HIGH_MIN, REPEAT_HIGH_MAX);
    entry.cls.mark        = in_window(pulse_time, MARK_MIN, MARK_MAX);
    entry.cls.one_high    = in_window(pulse_time, ONE_HIGH_MIN, ONE_HIGH_MAX);
  end

endmodule

[hw/rtl/nir_queue.sv]
// ----------------------------------------------------------------------------
// NEC IR decoder item queue
// Small register FIFO between the classifier and the decoder core.
// ----------------------------------------------------------------------------
module nir_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  nir_pkg::queue_entry_t push_data,
  input  logic                  pop,
  output nir_pkg::queue_entry_t pop_data,
  output logic                  empty,
  output logic                  full
);
  import nir_pkg::*;

  queue_entry_t           slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

  assign empty    = (count == '0);
  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue pushed while full");

endmodule

[hw/rtl/nir_back.sv]
// ----------------------------------------------------------------------------
// NEC IR decoder core
// Executes queued items on the frame state and holds the result register.
// ----------------------------------------------------------------------------
module nir_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  input  nir_pkg::queue_entry_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            address,
  output logic [7:0]            command,
  output logic [7:0]            repeat_count,
  output logic [1:0]            key_state
);
  import nir_pkg::*;

  logic [15:0]  hold_timeout;
  logic         edge_phase;
  logic         frame_started;
  pulse_class_t low_cls;
  pulse_class_t high_cls;
  logic [31:0]  shift_word;
  logic [5:0]   bit_index;
  logic [7:0]   repeats;
  logic [7:0]   repeats_seen;
  key_t         key_flag;
  logic [15:0]  hold_ticks;
  logic [7:0]   latched_address;
  logic [7:0]   latched_command;

  logic         edge_phase_next;
  logic         frame_started_next;
  pulse_class_t low_cls_next;
  pulse_class_t high_cls_next;
  logic [31:0]  shift_word_next;
  logic [5:0]   bit_index_next;
  logic [7:0]   repeats_next;
  logic [7:0]   repeats_seen_next;
  key_t         key_flag_next;
  logic [15:0]  hold_ticks_next;
  logic [7:0]   latched_address_next;
  logic [7:0]   latched_command_next;
  logic [15:0]  ticks_inc;

  assign cfg_ready = 1'b1;
  // State only advances when the result slot is free, so the outputs can
  // come straight from the state registers.
  assign pop          = !empty && (!out_valid || !out_stall);
  assign address      = latched_address;
  assign command      = latched_command;
  assign repeat_count = repeats_seen;
  assign key_state    = key_flag;
  assign ticks_inc    = hold_ticks + 16'd1;

  always_comb begin
    edge_phase_next      = edge_phase;
    frame_started_next   = frame_started;
    low_cls_next         = low_cls;
    high_cls_next        = high_cls;
    shift_word_next      = shift_word;
    bit_index_next       = bit_index;
    repeats_next         = repeats;
    repeats_seen_next    = repeats_seen;
    key_flag_next        = key_flag;
    hold_ticks_next      = hold_ticks;
    latched_address_next = latched_address;
    latched_command_next = latched_command;
    case (head.op)
      OP_EDGE: begin
        edge_phase_next = ~edge_phase;
        if (!edge_phase_next) begin
          low_cls_next = head.cls;
        end else if (frame_started) begin
          high_cls_next = head.cls;
        end else begin
          frame_started_next = 1'b1;
        end
        if (low_cls_next.leader_low && high_cls_next.leader_high) begin
          shift_word_next = '0;
          repeats_next    = '0;
          bit_index_next  = '0;
        end else if (low_cls_next.leader_low && high_cls_next.repeat_high) begin
          repeats_next = (repeats < REPEAT_CAP) ? repeats + 8'd1 : REPEAT_CAP;
        end
        if (edge_phase_next && low_cls_next.mark) begin
          if (high_cls_next.mark) begin
            shift_word_next[bit_index_next[4:0]] = 1'b0;
            bit_index_next = bit_index_next + 6'd1;
          end else if (high_cls_next.one_high) begin
            shift_word_next[bit_index_next[4:0]] = 1'b1;
            bit_index_next = bit_index_next + 6'd1;
          end
        end
        if (bit_index_next >= FRAME_BITS) begin
          bit_index_next = '0;
          key_flag_next  = KEY_HELD;
        end
      end
      OP_OVERFLOW: begin
        // A zero width matches no window, so cleared classes stand for zero.
        edge_phase_next    = 1'b0;
        frame_started_next = 1'b0;
        low_cls_next       = '0;
        high_cls_next      = '0;
      end
      OP_TICK: begin
        if (key_flag == KEY_HELD) begin
          if (ticks_inc > hold_timeout) begin
            hold_ticks_next = '0;
            key_flag_next   = KEY_PENDING;
          end else begin
            hold_ticks_next = ticks_inc;
          end
        end
      end
      OP_POLL: begin
        latched_address_next = checked_byte(shift_word[15:0]);
        latched_command_next = checked_byte(shift_word[31:16]);
        if (repeats != repeats_seen) begin
          key_flag_next     = KEY_HELD;
          repeats_seen_next = repeats;
        end else begin
          key_flag_next = KEY_RELEASED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout    <= HOLD_TIMEOUT_RESET;
      out_valid       <= 1'b0;
      edge_phase      <= 1'b0;
      frame_started   <= 1'b0;
      low_cls         <= '0;
      high_cls        <= '0;
      shift_word      <= '0;
      bit_index       <= '0;
      repeats         <= '0;
      repeats_seen    <= '0;
      key_flag        <= KEY_RELEASED;
      hold_ticks      <= '0;
      latched_address <= '0;
      latched_command <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hold_timeout <= cfg_data;
      end
      if (pop) begin
        out_valid       <= 1'b1;
        edge_phase      <= edge_phase_next;
        frame_started   <= frame_started_next;
        low_cls         <= low_cls_next;
        high_cls        <= high_cls_next;
        shift_word      <= shift_word_next;
        bit_index       <= bit_index_next;
        repeats         <= repeats_next;
        repeats_seen    <= repeats_seen_next;
        key_flag        <= key_flag_next;
        hold_ticks      <= hold_ticks_next;
        latched_address <= latched_address_next;
        latched_command <= latched_command_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst) bit_index < FRAME_BITS)
    else $error("bit index left the frame range");
  a_repeats_cap: assert property (@(posedge clk) disable iff (rst) repeats <= REPEAT_CAP)
    else $error("repeat counter above its cap");
  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst) pop |=> out_valid)
    else $error("executed item produced no result");

endmodule

[hw/rtl/nec_ir_pulse_decoder_top.sv]
// A result is registered in the core after its item has been stored in the queue.
// Throughput: the core executes one queued item per cycle unless out_stall holds a result.
// The four-entry queue lets the input keep flowing for four items while the output stalls.
// Reset (rst, synchronous) clears the queue, the frame state, the result register
// and sets the hold timeout to 100 ticks.
// ----------------------------------------------------------------------------
// NEC IR pulse decoder
// Decodes NEC infrared frames from captured pulse widths and key polls.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] pulse_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  address,
  output logic [7:0]  command,
  output logic [7:0]  repeat_count,
  output logic [1:0]  key_state
);
  import nir_pkg::*;

  queue_entry_t push_entry;
  queue_entry_t head_entry;
  logic         push;
  logic         pop;
  logic         empty;
  logic         full;

  nir_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .pulse_time (pulse_time),
    .full       (full),
    .push       (push),
    .entry      (push_entry)
  );

  nir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (head_entry),
    .empty     (empty),
    .full      (full)
  );

  nir_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .head         (head_entry),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .address      (address),
    .command      (command),
    .repeat_count (repeat_count),
    .key_state    (key_state)
  );

endmodule

[bench/tb_nec_ir_pulse_decoder_top.sv]
// ----------------------------------------------------------------------------
// NEC IR pulse decoder testbench
// Sends edge, overflow, tick and poll items through the decoder and checks
// every result against a cycle-free predictor of the frame, repeat and key
// logic. Well-formed frames with random bytes make up most of the traffic.
// Both handshakes idle and stall at random, and the hold timeout register is
// rewritten between phases.
// ----------------------------------------------------------------------------
module tb_nec_ir_pulse_decoder_top;
  import nir_pkg::*;

  // Pulse width windows in microseconds, inclusive at both ends.
  localparam logic [15:0] LEAD_LO_MIN = 16'd8500;
  localparam logic [15:0] LEAD_LO_MAX = 16'd9500;
  localparam logic [15:0] LEAD_HI_MIN = 16'd4000;
  localparam logic [15:0] LEAD_HI_MAX = 16'd5500;
  localparam logic [15:0] RPT_HI_MIN  = 16'd2000;
  localparam logic [15:0] RPT_HI_MAX  = 16'd3000;
  localparam logic [15:0] MARK_LO     = 16'd450;
  localparam logic [15:0] MARK_HI     = 16'd650;
  localparam logic [15:0] ONE_LO      = 16'd1450;
  localparam logic [15:0] ONE_HI      = 16'd1750;
  localparam logic [7:0]  RPT_LIMIT   = 8'd250;
  localparam int          LONG_HOLD   = 60;
  localparam int          PHASES      = 6;

  typedef struct {
    op_t         op;
    logic [15:0] t;
  } ir_item_t;

  typedef struct {
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] repeats;
    key_t       key;
  } key_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         op = OP_EDGE;
  logic [15:0] pulse_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  address;
  logic [7:0]  command;
  logic [7:0]  repeat_count;
  logic [1:0]  key_state;

  nec_ir_pulse_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .pulse_time   (pulse_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .address      (address),
    .command      (command),
    .repeat_count (repeat_count),
    .key_state    (key_state)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3200000;
    $display("TEST FAILED");
    $finish;
  end

  // Predicted decoder state, matching the block's reset values.
  logic        dec_phase = 1'b0;
  logic        dec_started = 1'b0;
  logic [15:0] dec_low = '0;
  logic [15:0] dec_high = '0;
  logic [31:0] dec_word = '0;
  logic [5:0]  dec_bits = '0;
  logic [7:0]  dec_repeats = '0;
  logic [7:0]  dec_repeats_seen = '0;
  key_t        dec_key = KEY_RELEASED;
  logic [15:0] dec_hold = '0;
  logic [7:0]  dec_addr = '0;
  logic [7:0]  dec_cmd = '0;
  logic [15:0] dec_timeout = 16'd100;

  ir_item_t    pulse_queue[$];
  key_report_t key_reports[$];
  int          queued_items = 0;
  int          issued_count = 0;
  int          accepted_count = 0;
  int          mismatches = 0;
  int          long_hold_asks = 0;
  int          long_hold_served = 0;
  int          long_hold_left = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  function automatic bit in_span(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic logic [7:0] verified_byte(logic [15:0] pair);
    return (pair[7:0] == ~pair[15:8]) ? pair[7:0] : 8'd0;
  endfunction

  task automatic decode_item(input ir_item_t item, output key_report_t rep);
    bit lead_low;
    case (item.op)
      OP_EDGE: begin
        dec_phase = ~dec_phase;
        if (!dec_phase) begin
          dec_low = item.t;
        end else if (dec_started) begin
          dec_high = item.t;
        end else begin
          dec_started = 1'b1;
        end
        lead_low = in_span(dec_low, LEAD_LO_MIN, LEAD_LO_MAX);
        if (lead_low && in_span(dec_high, LEAD_HI_MIN, LEAD_HI_MAX)) begin
          dec_word = '0;
          dec_repeats = '0;
          dec_bits = '0;
        end else if (lead_low && in_span(dec_high, RPT_HI_MIN, RPT_HI_MAX)) begin
          dec_repeats = (dec_repeats < RPT_LIMIT) ? dec_repeats + 8'd1 : RPT_LIMIT;
        end
        // Bits are only taken on a falling edge after a valid mark.
        if (dec_phase && in_span(dec_low, MARK_LO, MARK_HI)) begin
          if (in_span(dec_high, MARK_LO, MARK_HI)) begin
            dec_word[dec_bits[4:0]] = 1'b0;
            dec_bits = dec_bits + 6'd1;
          end else if (in_span(dec_high, ONE_LO, ONE_HI)) begin
            dec_word[dec_bits[4:0]] = 1'b1;
            dec_bits = dec_bits + 6'd1;
          end
        end
        if (dec_bits >= 6'd32) begin
          dec_bits = '0;
          dec_key = KEY_HELD;
        end
      end
      OP_OVERFLOW: begin
        dec_phase = 1'b0;
        dec_started = 1'b0;
        dec_low = '0;
        dec_high = '0;
      end
      OP_TICK: begin
        if (dec_key == KEY_HELD) begin
          dec_hold = dec_hold + 16'd1;
          if (dec_hold > dec_timeout) begin
            dec_hold = '0;
            dec_key = KEY_PENDING;
          end
        end
      end
      default: begin
        dec_addr = verified_byte(dec_word[15:0]);
        dec_cmd = verified_byte(dec_word[31:16]);
        if (dec_repeats != dec_repeats_seen) begin
          dec_key = KEY_HELD;
          dec_repeats_seen = dec_repeats;
        end else begin
          dec_key = KEY_RELEASED;
        end
      end
    endcase
    rep.address = dec_addr;
    rep.command = dec_cmd;
    rep.repeats = dec_repeats_seen;
    rep.key = dec_key;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Checks results first, then predicts the item taken at this edge.
  always @(posedge clk) begin : score
    key_report_t want;
    key_report_t fresh;
    ir_item_t    taken;
    if (!rst && out_valid && !out_stall) begin
      if (key_reports.size() == 0) begin
        $display("%0t: result with nothing expected, address %0d command %0d", $time,
                 address, command);
        mismatches++;
      end else begin
        want = key_reports.pop_front();
        check_field("address", want.address, address);
        check_field("command", want.command, command);
        check_field("repeat_count", want.repeats, repeat_count);
        check_field("key_state", {6'd0, want.key}, {6'd0, key_state});
      end
    end
    if (!rst && in_valid && !in_stall) begin
      taken.op = op;
      taken.t = pulse_time;
      decode_item(taken, fresh);
      key_reports.push_back(fresh);
      accepted_count++;
    end
  end

  // Item sender: holds a stalled item, otherwise takes the next one or idles.
  always @(negedge clk) begin : drive_items
    ir_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted_count != issued_count) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pulse_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      send_gap = $urandom_range(0, 6);
      in_valid <= 1'b0;
    end else begin
      next_item = pulse_queue.pop_front();
      op <= next_item.op;
      pulse_time <= next_item.t;
      in_valid <= 1'b1;
      issued_count++;
    end
  end

  // Result receiver stall, with one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_asks != long_hold_served) begin
      long_hold_served++;
      long_hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push(input op_t o, input logic [15:0] t);
    ir_item_t item;
    item.op = o;
    item.t = t;
    pulse_queue.push_back(item);
    queued_items++;
  endtask

  // Mostly random inside the window, with the window ends favored.
  function automatic logic [15:0] span(logic [15:0] lo, logic [15:0] hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic queue_frame(input logic [7:0] a, input logic [7:0] c, input bit spoil,
                             input int nbits, input int bad_bit);
    logic [31:0] word;
    word = {~c, c, ~a, a};
    if (spoil) word = word ^ (32'd1 << $urandom_range(0, 31));
    push(OP_EDGE, 16'($urandom));
    push(OP_EDGE, span(LEAD_LO_MIN, LEAD_LO_MAX));
    push(OP_EDGE, span(LEAD_HI_MIN, LEAD_HI_MAX));
    for (int i = 0; i < nbits; i++) begin
      push(OP_EDGE, span(MARK_LO, MARK_HI));
      if (i == bad_bit) push(OP_EDGE, 16'($urandom_range(651, 1449)));
      else push(OP_EDGE, word[i] ? span(ONE_LO, ONE_HI) : span(MARK_LO, MARK_HI));
    end
    push(OP_EDGE, span(MARK_LO, MARK_HI));
  endtask

  task automatic queue_repeats(input int n);
    for (int i = 0; i < n; i++) begin
      push(OP_EDGE, span(LEAD_LO_MIN, LEAD_LO_MAX));
      push(OP_EDGE, span(RPT_HI_MIN, RPT_HI_MAX));
    end
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) push(OP_TICK, 16'($urandom));
  endtask

  task automatic queue_random(input int budget);
    int stop_at;
    int kind;
    stop_at = queued_items + budget;
    while (queued_items < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        if ($urandom_range(0, 9) < 7) push(OP_OVERFLOW, 16'($urandom));
        queue_frame(8'($urandom), 8'($urandom), $urandom_range(0, 5) == 0, 32, -1);
        queue_repeats($urandom_range(0, 4));
        queue_ticks($urandom_range(0, 25));
        push(OP_POLL, 16'($urandom));
      end else if (kind < 11) begin
        push(OP_OVERFLOW, 16'($urandom));
        if ($urandom_range(0, 1)) begin
          queue_frame(8'($urandom), 8'($urandom), 1'b0, $urandom_range(0, 31), -1);
        end else begin
          queue_frame(8'($urandom), 8'($urandom), 1'b0, 32, $urandom_range(0, 31));
        end
        push(OP_POLL, 16'($urandom));
      end else if (kind < 13) begin
        queue_repeats($urandom_range(1, 6));
        push(OP_POLL, 16'($urandom));
      end else if (kind < 15) begin
        queue_ticks($urandom_range(1, 30));
        push(OP_POLL, 16'($urandom));
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 8)) begin
          push(op_t'($urandom_range(0, 3)),
               $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 10000)));
        end
      end else if (kind == 17) begin
        push(OP_OVERFLOW, 16'($urandom));
        push(OP_POLL, 16'($urandom));
      end else begin
        push(OP_POLL, 16'($urandom));
        push(OP_POLL, 16'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pulse_queue.size() != 0 || issued_count != accepted_count ||
           key_reports.size() != 0);
  endtask

  // Called at a falling edge with both item channels idle.
  task automatic write_hold_timeout(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    dec_timeout = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] hold_settings [PHASES];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every op, window ends, ignored pairs, leader and repeat.
    push(OP_POLL, 16'hffff);
    push(OP_TICK, 16'h0000);
    push(OP_OVERFLOW, 16'hffff);
    push(OP_EDGE, 16'd0);
    push(OP_EDGE, LEAD_LO_MAX);
    push(OP_EDGE, LEAD_HI_MIN);
    push(OP_EDGE, MARK_LO);
    push(OP_EDGE, MARK_HI);
    push(OP_EDGE, MARK_HI);
    push(OP_EDGE, ONE_LO);
    push(OP_EDGE, MARK_LO);
    push(OP_EDGE, ONE_HI);
    push(OP_EDGE, MARK_LO - 16'd1);
    push(OP_EDGE, MARK_HI + 16'd1);
    push(OP_EDGE, LEAD_LO_MIN);
    push(OP_EDGE, RPT_HI_MIN);
    push(OP_POLL, 16'h0000);
    push(OP_EDGE, LEAD_LO_MAX + 16'd1);
    push(OP_EDGE, RPT_HI_MAX);
    push(OP_EDGE, LEAD_LO_MIN);
    push(OP_EDGE, LEAD_HI_MAX);
    push(OP_POLL, 16'h5a5a);
    push(OP_EDGE, 16'hffff);
    push(OP_TICK, 16'hffff);
    push(OP_POLL, 16'h0000);
    wait_idle();

    hold_settings = '{16'd0, 16'd65534, 16'd3, 16'($urandom_range(1, 40)), 16'd100,
                      16'($urandom_range(0, 12))};
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      write_hold_timeout(hold_settings[p]);
      // A long repeat train drives the repeat counter up toward its cap.
      if (p == 1) begin
        queue_repeats(130);
        push(OP_POLL, 16'($urandom));
      end
      queue_random(130);
      if (p == 2) long_hold_asks++;
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
